@@ sv/tftw_pkg.sv @@
package tftw_pkg;

  // Panel command bytes.
  localparam logic [7:0] CMD_COLUMN_ADDR  = 8'h2A;
  localparam logic [7:0] CMD_ROW_ADDR     = 8'h2B;
  localparam logic [7:0] CMD_MEMORY_WRITE = 8'h2C;

  // Register reset values.
  localparam logic [7:0] COLUMN_OFFSET_RESET = 8'h1A;
  localparam logic [7:0] ROW_OFFSET_RESET    = 8'h01;

  // Leftmost glyph pixel, also used as the single pixel of a pixel request.
  localparam logic [7:0] MASK_TOP_BIT = 8'h80;

  // The window sequence has eleven bytes; this is the index of the final one.
  localparam logic [3:0] WIN_LAST_STEP = 4'd10;

  localparam int QUEUE_DEPTH_DEFAULT = 2;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;

  typedef enum logic [1:0] {
    KIND_WINDOW = 2'd0,
    KIND_PIXEL  = 2'd1,
    KIND_GLYPH  = 2'd2,
    KIND_UNUSED = 2'd3
  } kind_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_COLUMN_OFFSET = 2'd0,
    REG_ROW_OFFSET    = 2'd1,
    REG_NONE_2        = 2'd2,
    REG_NONE_3        = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  x_start;
    logic [7:0]  y_start;
    logic [7:0]  x_end;
    logic [7:0]  y_end;
    logic [15:0] fore_color;
    logic [15:0] back_color;
    logic [7:0]  mask_byte;
  } tftw_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_data;
    logic       last;
  } tftw_out_t;

  // Work descriptor handed from the front end to the byte sequencer.
  // Pixel and glyph requests share one form: emit marks pixels to send,
  // sel picks the foreground colour for a pixel.
  typedef struct packed {
    logic        is_win;
    logic [7:0]  col_first;
    logic [7:0]  col_final;
    logic [7:0]  row_first;
    logic [7:0]  row_final;
    logic [15:0] fore;
    logic [15:0] back;
    logic [7:0]  emit;
    logic [7:0]  sel;
  } tftw_desc_t;

endpackage

@@ sv/tftw_front.sv @@
module tftw_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [tftw_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [tftw_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                in_valid,
  input  tftw_pkg::tftw_in_t                  in_data,
  input  logic                                q_full,
  output logic                                q_push,
  output tftw_pkg::tftw_desc_t                q_desc
);

  logic [7:0] col_off_r, col_off_nxt;
  logic [7:0] row_off_r, row_off_nxt;
  logic       keep;
  logic       transparent;

  always_comb begin
    col_off_nxt = col_off_r;
    row_off_nxt = row_off_r;
    if (cfg_we) begin
      case (tftw_pkg::reg_index_t'(cfg_index))
        tftw_pkg::REG_COLUMN_OFFSET: col_off_nxt = cfg_wdata;
        tftw_pkg::REG_ROW_OFFSET:    row_off_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_off_r <= tftw_pkg::COLUMN_OFFSET_RESET;
      row_off_r <= tftw_pkg::ROW_OFFSET_RESET;
    end else begin
      col_off_r <= col_off_nxt;
      row_off_r <= row_off_nxt;
    end
  end

  // Classify the request and build its descriptor.
  always_comb begin
    transparent      = (in_data.fore_color == in_data.back_color);
    q_desc           = '0;
    q_desc.col_first = in_data.x_start + col_off_r;
    q_desc.col_final = in_data.x_end + col_off_r;
    q_desc.row_first = in_data.y_start + row_off_r;
    q_desc.row_final = in_data.y_end + row_off_r;
    q_desc.fore      = in_data.fore_color;
    q_desc.back      = in_data.back_color;
    keep             = 1'b0;
    case (tftw_pkg::kind_t'(in_data.kind))
      tftw_pkg::KIND_WINDOW: begin
        q_desc.is_win = 1'b1;
        keep          = 1'b1;
      end
      tftw_pkg::KIND_PIXEL: begin
        q_desc.emit = tftw_pkg::MASK_TOP_BIT;
        q_desc.sel  = tftw_pkg::MASK_TOP_BIT;
        keep        = 1'b1;
      end
      tftw_pkg::KIND_GLYPH: begin
        q_desc.emit = in_data.mask_byte | {8{!transparent}};
        q_desc.sel  = in_data.mask_byte;
        // A transparent glyph with no set bits produces nothing.
        keep        = (q_desc.emit != 8'h00);
      end
      default: keep = 1'b0;
    endcase
  end

  assign q_push = in_valid && !q_full && keep;

endmodule

@@ sv/tftw_queue.sv @@
module tftw_queue #(
  parameter int DEPTH = tftw_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  tftw_pkg::tftw_desc_t push_desc,
  input  logic                 pop,
  output logic                 full,
  output logic                 nonempty,
  output tftw_pkg::tftw_desc_t head
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  tftw_pkg::tftw_desc_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full     = (count_r == CNT_FULL);
  assign nonempty = (count_r != '0);
  assign head     = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

@@ sv/tftw_back.sv @@
module tftw_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_nonempty,
  input  tftw_pkg::tftw_desc_t q_head,
  output logic                 q_pop,
  output logic                 busy,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tftw_pkg::tftw_out_t  out_data
);

  tftw_pkg::tftw_desc_t desc_r, desc_nxt;
  logic                 busy_r, busy_nxt;
  logic [3:0]           step_r, step_nxt;
  logic [7:0]           emit_r, emit_nxt;
  logic                 out_valid_r, out_valid_nxt;
  tftw_pkg::tftw_out_t  out_data_r, out_data_nxt;

  logic [2:0]           pos;
  logic [15:0]          pix_color;
  logic [7:0]           emit_left;
  tftw_pkg::tftw_out_t  cur;
  logic                 fire;
  logic                 done;

  // Leftmost pixel still to send; the highest set bit wins.
  always_comb begin
    pos = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (emit_r[i]) pos = 3'(i);
    end
    pix_color = desc_r.sel[pos] ? desc_r.fore : desc_r.back;
    emit_left = emit_r & ~(8'(8'd1 << pos));
  end

  always_comb begin
    cur = '0;
    if (desc_r.is_win) begin
      cur.is_data = 1'b1;
      case (step_r)
        4'd0: begin
          cur.out_byte = tftw_pkg::CMD_COLUMN_ADDR;
          cur.is_data  = 1'b0;
        end
        4'd2:    cur.out_byte = desc_r.col_first;
        4'd4:    cur.out_byte = desc_r.col_final;
        4'd5: begin
          cur.out_byte = tftw_pkg::CMD_ROW_ADDR;
          cur.is_data  = 1'b0;
        end
        4'd7:    cur.out_byte = desc_r.row_first;
        4'd9:    cur.out_byte = desc_r.row_final;
        4'd10: begin
          cur.out_byte = tftw_pkg::CMD_MEMORY_WRITE;
          cur.is_data  = 1'b0;
        end
        default: cur.out_byte = 8'h00;
      endcase
      cur.last = (step_r == tftw_pkg::WIN_LAST_STEP);
    end else begin
      cur.is_data  = 1'b1;
      cur.out_byte = step_r[0] ? pix_color[7:0] : pix_color[15:8];
      cur.last     = step_r[0] && (emit_left == 8'h00);
    end
  end

  assign fire  = busy_r && (!out_valid_r || !out_stall);
  assign done  = fire && cur.last;
  assign q_pop = q_nonempty && (!busy_r || done);

  always_comb begin
    desc_nxt      = desc_r;
    busy_nxt      = busy_r;
    step_nxt      = step_r;
    emit_nxt      = emit_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (fire) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = cur;
      if (desc_r.is_win) begin
        step_nxt = step_r + 1'b1;
      end else begin
        step_nxt = {3'b000, !step_r[0]};
        if (step_r[0]) begin
          emit_nxt = emit_left;
        end
      end
      if (done) begin
        busy_nxt = 1'b0;
      end
    end

    if (q_pop) begin
      desc_nxt = q_head;
      emit_nxt = q_head.emit;
      step_nxt = 4'd0;
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      step_r      <= 4'd0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    desc_r     <= desc_nxt;
    emit_r     <= emit_nxt;
    out_data_r <= out_data_nxt;
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ sv/tft_window_pixel_glyph_writer.sv @@
// When the queue and the byte sequencer are empty, an accepted request passes through
// the queue, the descriptor register and the output register before its first byte shows.
// The sequencer sends one output byte per cycle while out_stall is low; a request has
// 11 bytes for a window, 2 for a pixel and up to 16 for a glyph byte.
// Requests that produce no bytes are taken by the front end alone and never queued.
// Reset (rst_n low, synchronous) empties the queue and sequencer and restores offsets.
module tft_window_pixel_glyph_writer #(
  parameter int QUEUE_DEPTH = tftw_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [tftw_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tftw_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  tftw_pkg::tftw_in_t               in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output tftw_pkg::tftw_out_t              out_data
);

  // The front end holds the two offset registers, decodes each request and
  // folds the offsets into the window coordinates at acceptance time. Pixel
  // and glyph requests become a common pixel-list descriptor, and requests
  // that produce no bytes are dropped here without touching the queue.
  //
  // The queue between the two halves lets the front end keep accepting while
  // the sequencer is still streaming a long glyph, and lets the sequencer keep
  // running when the input side has nothing to offer.
  //
  // The back end walks one descriptor a byte per cycle, while the output is not
  // stalled, into a registered output stage. It takes the next descriptor in the
  // same cycle that it sends the final byte of the current one, so consecutive
  // transactions leave no gap on the output.

  logic                 q_full;
  logic                 q_push;
  logic                 q_pop;
  logic                 q_nonempty;
  logic                 back_busy;
  tftw_pkg::tftw_desc_t q_desc;
  tftw_pkg::tftw_desc_t q_head;

  tftw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_desc    (q_desc)
  );

  tftw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (q_desc),
    .pop       (q_pop),
    .full      (q_full),
    .nonempty  (q_nonempty),
    .head      (q_head)
  );

  tftw_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .busy       (back_busy),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  // The input stalls only while the queue is full.
  assign in_stall = q_full;

  // Reset leaves no byte pending on the output.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // The only command byte that closes a transaction is the memory write command.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.is_data && out_data.last |->
      out_data.out_byte == tftw_pkg::CMD_MEMORY_WRITE)
    else $error("transaction closed by a wrong command byte");

  // Command bytes are only the three panel commands.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.is_data |->
      out_data.out_byte == tftw_pkg::CMD_COLUMN_ADDR ||
      out_data.out_byte == tftw_pkg::CMD_ROW_ADDR ||
      out_data.out_byte == tftw_pkg::CMD_MEMORY_WRITE)
    else $error("unexpected command byte");

  // A queued descriptor never leaves the sequencer idle.
  assert property (@(posedge clk) disable iff (!rst_n)
    q_nonempty |=> back_busy)
    else $error("sequencer idle with work queued");

endmodule
